[src/isp_pkg.sv]
// isp_pkg: shared types and constants for the interpolating sample player
// used by isp_blend and interpolating_sample_player_core
// no dependencies
package isp_pkg;

  // default parameter values
  localparam int unsigned DEF_STORE_DEPTH   = 65536;
  localparam int unsigned DEF_SAMPLE_BITS   = 24;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned FRAME_ADDR_W = 16;
  localparam int unsigned POS_W      = 34;
  localparam int unsigned STEP_W     = 20;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;

  // reset values of the registers
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [LEN_W-1:0]  LEN_RESET  = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_PLAY    = 2'd2
  } isp_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_RATIO    = 1'b0,
    REG_SAMPLE_LENGTH = 1'b1
  } isp_reg_t;

  // pipeline load strobes for the blend datapath
  typedef struct packed {
    logic ld_diff;
    logic ld_prod;
    logic ld_out;
  } isp_stage_en_t;

endpackage

[src/isp_store.sv]
// isp_store: one sample store, one write port and two registered read ports
// depends on nothing but its parameters
module isp_store #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data held while the consumer stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[src/isp_blend.sv]
// isp_blend: three-stage linear blend of two neighbouring samples
// depends on isp_pkg (stage load strobes)
module isp_blend #(
  parameter int unsigned SAMPLE_BITS   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  isp_pkg::isp_stage_en_t    en,
  input  logic [SAMPLE_BITS-1:0]    a,
  input  logic [SAMPLE_BITS-1:0]    b,
  input  logic [FRACTION_BITS-1:0]  frac,
  input  logic                      act,
  output logic [SAMPLE_BITS-1:0]    result
);
  import isp_pkg::*;

  localparam int unsigned P_W = SAMPLE_BITS + FRACTION_BITS + 2;
  localparam logic signed [P_W-1:0] HALF = P_W'(1) <<< (FRACTION_BITS - 1);

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS-1:0] a_d;
  logic        [FRACTION_BITS-1:0] frac_d;
  logic signed [P_W-1:0]         prod;
  logic signed [SAMPLE_BITS-1:0] a_p;
  logic signed [P_W-1:0]         rounded;
  logic signed [P_W-1:0]         blended;

  always_ff @(posedge clk) begin
    if (en.ld_diff) begin
      diff   <= (SAMPLE_BITS+1)'($signed(b)) - (SAMPLE_BITS+1)'($signed(a));
      a_d    <= $signed(a);
      frac_d <= frac;
    end
    if (en.ld_prod) begin
      prod <= P_W'(diff) * P_W'($signed({1'b0, frac_d}));
      a_p  <= a_d;
    end
    if (en.ld_out) begin
      result <= act ? blended[SAMPLE_BITS-1:0] : '0;
    end
  end

  // ties round upward
  always_comb begin
    rounded = (prod + HALF) >>> FRACTION_BITS;
    blended = P_W'(a_p) + rounded;
  end

endmodule

[src/interpolating_sample_player_core.sv]
// interpolating_sample_player_core: stereo sample playback voice, top level
// depends on isp_pkg, isp_store and isp_blend
//
// usage
//   input channel (in_valid/in_ready) takes one command word a cycle while in_ready is high:
//   write stores a stereo frame at frame_address, restart rewinds the note,
//   play produces one interpolated stereo frame on the output channel
//   output channel (out_valid/out_ready) carries left_out, right_out, active
//   and sample_ended; write and restart give no output word
//   configuration channel (cfg_valid/cfg_ready) writes step_ratio or
//   sample_length; always ready, to be used only while the voice is idle
//   throughput: one word a cycle while the receiver keeps up, set by the
//   position add and the two read ports of each sample store
//   a play word moves through the store read, difference and product
//   registers in that order, then is rounded into the output register
//   reset: position zero, voice ended, step one frame, length zero,
//   pipeline empty; stores are left as they are
//   when the receiver stalls the pipeline keeps filling its empty stages,
//   then in_ready falls; no word is dropped or repeated
//   STORE_DEPTH must be a power of two
module interpolating_sample_player_core #(
  parameter int unsigned STORE_DEPTH   = isp_pkg::DEF_STORE_DEPTH,
  parameter int unsigned SAMPLE_BITS   = isp_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned FRACTION_BITS = isp_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [isp_pkg::CMD_W-1:0]         cmd,
  input  logic [isp_pkg::FRAME_ADDR_W-1:0]  frame_address,
  input  logic [SAMPLE_BITS-1:0]            left_in,
  input  logic [SAMPLE_BITS-1:0]            right_in,
  // output words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SAMPLE_BITS-1:0]            left_out,
  output logic [SAMPLE_BITS-1:0]            right_out,
  output logic                              active,
  output logic                              sample_ended,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [isp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [isp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import isp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned WIDE_W = POS_W + ADDR_W;

  // registers
  logic [STEP_W-1:0] step_ratio;
  logic [LEN_W-1:0]  sample_length;
  logic [POS_W-1:0]  read_position;
  logic              ended_flag;

  // pipeline valid and activity bits: store read, difference, product, output
  logic v_rd, v_diff, v_prod;
  logic act_rd, act_diff, act_prod;
  logic [FRACTION_BITS-1:0] frac_rd;

  logic          rdy_out, rdy_prod, rdy_diff, rdy_rd;
  isp_stage_en_t en;

  logic in_acc, play_acc, write_acc, restart_acc;

  logic [POS_W-1:0]  idx_full;
  logic [POS_W:0]    idx_p1;
  logic              ends_now;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [WIDE_W-1:0] idx_wide, idx_p1_wide, wr_wide;

  logic [SAMPLE_BITS-1:0] left_a, left_b, right_a, right_b;

  assign cfg_ready = 1'b1;

  // ready ripples back from the output register
  always_comb begin
    rdy_out    = !out_valid || out_ready;
    en.ld_out  = v_prod && rdy_out;
    rdy_prod   = !v_prod || rdy_out;
    en.ld_prod = v_diff && rdy_prod;
    rdy_diff   = !v_diff || rdy_prod;
    en.ld_diff = v_rd && rdy_diff;
    rdy_rd     = !v_rd || rdy_diff;
    in_ready   = rdy_rd;
  end

  // command decode
  always_comb begin
    in_acc      = in_valid && in_ready;
    play_acc    = 1'b0;
    write_acc   = 1'b0;
    restart_acc = 1'b0;
    case (cmd)
      CMD_WRITE:   write_acc   = in_acc;
      CMD_RESTART: restart_acc = in_acc;
      CMD_PLAY:    play_acc    = in_acc;
      default:     ;
    endcase
  end

  // position split into frame index and fraction, end test on idx+1
  always_comb begin
    idx_full    = read_position >> FRACTION_BITS;
    idx_p1      = {1'b0, idx_full} + (POS_W+1)'(1);
    ends_now    = ended_flag || (idx_p1 >= (POS_W+1)'(sample_length));
    idx_wide    = WIDE_W'(idx_full);
    idx_p1_wide = WIDE_W'(idx_p1);
    wr_wide     = WIDE_W'(frame_address);
    // indices wrap modulo the store depth
    rd_addr_a   = idx_wide[ADDR_W-1:0];
    rd_addr_b   = idx_p1_wide[ADDR_W-1:0];
    wr_addr     = wr_wide[ADDR_W-1:0];
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= STEP_RESET;
      sample_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_RATIO:    step_ratio    <= cfg_data[STEP_W-1:0];
        REG_SAMPLE_LENGTH: sample_length <= cfg_data[LEN_W-1:0];
        default:           ;
      endcase
    end
  end

  // voice state: position advances only on an active play
  always_ff @(posedge clk) begin
    if (rst) begin
      read_position <= '0;
      ended_flag    <= 1'b1;
    end else if (restart_acc) begin
      read_position <= '0;
      ended_flag    <= 1'b0;
    end else if (play_acc) begin
      if (ends_now) begin
        ended_flag <= 1'b1;
      end else begin
        read_position <= read_position + POS_W'(step_ratio);
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd      <= 1'b0;
      v_diff    <= 1'b0;
      v_prod    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (play_acc) begin
        v_rd <= 1'b1;
      end else if (en.ld_diff) begin
        v_rd <= 1'b0;
      end
      if (en.ld_diff) begin
        v_diff <= 1'b1;
      end else if (en.ld_prod) begin
        v_diff <= 1'b0;
      end
      if (en.ld_prod) begin
        v_prod <= 1'b1;
      end else if (en.ld_out) begin
        v_prod <= 1'b0;
      end
      if (en.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // side data that travels with each play word
  always_ff @(posedge clk) begin
    if (play_acc) begin
      act_rd  <= !ends_now;
      frac_rd <= read_position[FRACTION_BITS-1:0];
    end
    if (en.ld_diff) begin
      act_diff <= act_rd;
    end
    if (en.ld_prod) begin
      act_prod <= act_diff;
    end
    if (en.ld_out) begin
      active <= act_prod;
    end
  end

  assign sample_ended = !active;

  // a write lands before any later play reads the store, so no forwarding
  isp_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_left_store (
    .clk     (clk),
    .we      (write_acc),
    .waddr   (wr_addr),
    .wdata   (left_in),
    .re      (play_acc),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (left_a),
    .rdata_b (left_b)
  );

  isp_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_right_store (
    .clk     (clk),
    .we      (write_acc),
    .waddr   (wr_addr),
    .wdata   (right_in),
    .re      (play_acc),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (right_a),
    .rdata_b (right_b)
  );

  // one blend per channel, sharing the stage strobes
  isp_blend #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_left_blend (
    .clk    (clk),
    .en     (en),
    .a      (left_a),
    .b      (left_b),
    .frac   (frac_rd),
    .act    (act_prod),
    .result (left_out)
  );

  isp_blend #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_right_blend (
    .clk    (clk),
    .en     (en),
    .a      (right_a),
    .b      (right_b),
    .frac   (frac_rd),
    .act    (act_prod),
    .result (right_out)
  );

endmodule
